### src/scs_pkg.sv
// Shared types and constants for the stick center-split scaler.
// No dependencies; imported by scs_div and stick_center_split_scaler.
package scs_pkg;

    // Width of the calibration limit registers
    localparam int CFG_BITS = 12;

    // Quotient bits of the scaled half-offset (500 < 2**9)
    localparam int QB = 9;

    // Output width and scale constants
    localparam int          POS_BITS   = 11;
    localparam logic [9:0]  HALF_SCALE = 10'd500;
    localparam logic [9:0]  FULL_SCALE = 10'd1000;
    localparam logic [10:0] POS_BASE   = 11'd1000;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_LIMIT_HIGH   = 2'd0,
        REG_LIMIT_LOW    = 2'd1,
        REG_LIMIT_MIDDLE = 2'd2,
        REG_REVERSE_DIR  = 2'd3
    } cfg_idx_t;

    // Per-request control carried alongside the divider data
    typedef struct packed {
        logic upper;    // sample at or above the middle point
        logic reverse;  // mirror the result about center
        logic sat;      // offset reaches the half-span, result pinned to 500
    } scs_side_t;

endpackage

### src/scs_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on scs_pkg (QB, scs_side_t).
module scs_div #(
    parameter int AW = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_vld,
    input  logic [AW+scs_pkg::QB-1:0]       in_num,
    input  logic [AW-1:0]                   in_span,
    input  scs_pkg::scs_side_t              in_side,
    output logic                            out_vld,
    output logic [scs_pkg::QB-1:0]          out_quo,
    output scs_pkg::scs_side_t              out_side
);
    import scs_pkg::*;

    localparam int PW = AW + QB;

    // Stage registers; index k holds the state after k quotient bits
    logic [QB:1]   vld_reg;
    logic [PW-1:0] rem_reg  [1:QB];
    logic [QB-1:0] quo_reg  [1:QB];
    logic [AW-1:0] span_reg [1:QB];
    scs_side_t     side_reg [1:QB];

    genvar i;
    generate
        for (i = 0; i < QB; i++) begin : g_stage
            localparam int BIT = QB - 1 - i;

            logic          src_vld;
            logic [PW-1:0] src_rem;
            logic [QB-1:0] src_quo;
            logic [AW-1:0] src_span;
            scs_side_t     src_side;
            logic [PW-1:0] trial;
            logic          ge;
            logic [PW-1:0] rem_next;
            logic [QB-1:0] quo_next;

            // Stage source: the divider inputs or the previous stage
            if (i == 0) begin : g_first
                assign src_vld  = in_vld;
                assign src_rem  = in_num;
                assign src_quo  = '0;
                assign src_span = in_span;
                assign src_side = in_side;
            end
            else begin : g_next
                assign src_vld  = vld_reg[i];
                assign src_rem  = rem_reg[i];
                assign src_quo  = quo_reg[i];
                assign src_span = span_reg[i];
                assign src_side = side_reg[i];
            end

            // Compare and subtract against the shifted divisor
            assign trial    = PW'(src_span) << BIT;
            assign ge       = (src_rem >= trial);
            assign rem_next = ge ? (src_rem - trial) : src_rem;
            assign quo_next = QB'({src_quo, ge});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i+1] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[i+1] <= src_vld;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i+1]  <= rem_next;
                    quo_reg[i+1]  <= quo_next;
                    span_reg[i+1] <= src_span;
                    side_reg[i+1] <= src_side;
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[QB];
    assign out_quo  = quo_reg[QB];
    assign out_side = side_reg[QB];

endmodule

### src/stick_center_split_scaler.sv
// Top level of the stick center-split scaler: config registers, front end, output stage.
// Depends on scs_pkg and scs_div.

// Maps one ADC sample to a 1000..2000 stick position, 1500 at the calibrated
// middle point. Each side of the middle is scaled on its own half-span as
// floor(500 * offset / span), saturating at 500; reverse_dir mirrors the result.
// A sample is taken every cycle unless sample_stall is raised. Its position passes
// twelve register stages: one offset stage, one multiply stage, nine divider stages
// (one quotient bit each) and the output register. A stall on the position side
// while a position is presented holds the whole pipeline and is passed straight back
// as sample_stall. Limits are written through the cfg port, which is always ready;
// write them only while the pipeline is empty.
module stick_center_split_scaler #(
    parameter int ADC_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Sample channel
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  logic [ADC_BITS-1:0]               sample,
    // Position channel
    output logic                              position_valid,
    input  logic                              position_stall,
    output logic [scs_pkg::POS_BITS-1:0]      position,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  scs_pkg::cfg_idx_t                 cfg_index,
    input  logic [scs_pkg::CFG_BITS-1:0]      cfg_data
);
    import scs_pkg::*;

    localparam int AW = ADC_BITS;
    localparam int PW = AW + QB;

    // Configuration registers
    logic [CFG_BITS-1:0] limit_high_reg;
    logic [CFG_BITS-1:0] limit_low_reg;
    logic [CFG_BITS-1:0] limit_middle_reg;
    logic                reverse_dir_reg;

    // Pipeline advance
    logic en;

    // Front end (offset and span)
    logic [AW-1:0] hi, lo, mid;
    logic          upper;
    logic [AW-1:0] off_next;
    logic [AW-1:0] span_next;
    logic          a_vld_reg;
    logic [AW-1:0] a_off_reg;
    logic [AW-1:0] a_span_reg;
    scs_side_t     a_side_reg;
    scs_side_t     a_side_next;

    // Multiply stage
    logic          b_vld_reg;
    logic [PW-1:0] b_prod_reg;
    logic [AW-1:0] b_span_reg;
    scs_side_t     b_side_reg;
    scs_side_t     b_side_next;

    // Divider output
    logic          d_vld;
    logic [QB-1:0] d_quo;
    scs_side_t     d_side;

    // Output stage
    logic [9:0]          q;
    logic [9:0]          half;
    logic [9:0]          half_dir;
    logic [POS_BITS-1:0] position_next;
    logic                out_vld_reg;
    logic [POS_BITS-1:0] position_reg;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_high_reg   <= 12'd4095;
            limit_low_reg    <= 12'd0;
            limit_middle_reg <= 12'd2048;
            reverse_dir_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LIMIT_HIGH:   limit_high_reg   <= cfg_data;
                REG_LIMIT_LOW:    limit_low_reg    <= cfg_data;
                REG_LIMIT_MIDDLE: limit_middle_reg <= cfg_data;
                REG_REVERSE_DIR:  reverse_dir_reg  <= cfg_data[0];
            endcase
        end
    end

    // Global stall: everything holds while a finished position waits
    assign en           = !(out_vld_reg && position_stall);
    assign sample_stall = !en;

    // Front end: pick the side, offset from middle and clamped half-span
    assign hi    = AW'(limit_high_reg);
    assign lo    = AW'(limit_low_reg);
    assign mid   = AW'(limit_middle_reg);
    assign upper = (sample >= mid);

    always_comb
    begin
        if (upper)
        begin
            off_next  = sample - mid;
            span_next = (hi > mid) ? (hi - mid) : AW'(1);
        end
        else
        begin
            off_next  = mid - sample;
            span_next = (mid > lo) ? (mid - lo) : AW'(1);
        end
        a_side_next         = '0;
        a_side_next.upper   = upper;
        a_side_next.reverse = reverse_dir_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_off_reg  <= off_next;
            a_span_reg <= span_next;
            a_side_reg <= a_side_next;
        end
    end

    // Multiply by 500 and flag saturation (offset at or beyond the span)
    always_comb
    begin
        b_side_next     = a_side_reg;
        b_side_next.sat = (a_off_reg >= a_span_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_prod_reg <= PW'(a_off_reg) * PW'(HALF_SCALE);
            b_span_reg <= a_span_reg;
            b_side_reg <= b_side_next;
        end
    end

    // Quotient of 500 * offset / span
    scs_div #(
        .AW (AW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (b_vld_reg),
        .in_num   (b_prod_reg),
        .in_span  (b_span_reg),
        .in_side  (b_side_reg),
        .out_vld  (d_vld),
        .out_quo  (d_quo),
        .out_side (d_side)
    );

    // Combine side, saturation and mirror into the final position
    always_comb
    begin
        q        = d_side.sat ? HALF_SCALE : 10'(d_quo);
        half     = d_side.upper ? (HALF_SCALE + q) : (HALF_SCALE - q);
        half_dir = d_side.reverse ? (FULL_SCALE - half) : half;
        position_next = POS_BITS'(half_dir) + POS_BASE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= d_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            position_reg <= position_next;
        end
    end

    assign position_valid = out_vld_reg;
    assign position       = position_reg;

`ifndef ASSERT_OFF
    // Delivered positions stay in the 1000..2000 band
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        position_valid |-> (position >= 11'd1000) && (position <= 11'd2000))
        else $error("position out of range");

    // Unsaturated quotient must land below the half scale
    a_quo_below: assert property (@(posedge clk) disable iff (!rst_n)
        (d_vld && !d_side.sat) |-> (10'(d_quo) < HALF_SCALE))
        else $error("divider quotient too large without saturation");

    // A stalled output holds the pipeline, so the divider output cannot move
    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && position_stall && d_vld) |=> d_vld && $stable(d_quo))
        else $error("divider advanced during stall");
`endif

endmodule

### test/tb_stick_center_split_scaler.sv
// Self-checking testbench for stick_center_split_scaler: directed and random sample requests,
// all calibration registers, idle/stall mixes and a long output hold.
// Depends on scs_pkg and the stick_center_split_scaler RTL, which in turn needs scs_div.
module tb_stick_center_split_scaler;
    timeunit 1ns;
    timeprecision 1ps;

    import scs_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int PIPE_LATENCY   = 12;
    localparam int DRAIN_CYCLES   = PIPE_LATENCY + 8;
    localparam int HOLD_LEN       = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_SET  = 50;

    logic                clk;
    logic                rst_n;
    logic                sample_valid;
    logic                sample_stall;
    logic [11:0]         sample;
    logic                position_valid;
    logic                position_stall;
    logic [POS_BITS-1:0] position;
    logic                cfg_valid;
    logic                cfg_ready;
    cfg_idx_t            cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    // Testbench copy of the calibration registers
    logic [11:0] cal_high    = 12'd4095;
    logic [11:0] cal_low     = 12'd0;
    logic [11:0] cal_mid     = 12'd2048;
    logic        cal_reverse = 1'b0;

    logic [POS_BITS-1:0] expected_positions[$];

    int errors            = 0;
    int samples_sent      = 0;
    int positions_checked = 0;
    int idle_cycles       = 0;
    int send_idle_pct     = 0;
    int recv_stall_pct    = 0;
    bit hold_req          = 1'b0;

    stick_center_split_scaler DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample         (sample),
        .position_valid (position_valid),
        .position_stall (position_stall),
        .position       (position),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // Expected position for one sample under the current calibration
    function automatic logic [POS_BITS-1:0] predict_position(logic [11:0] value);
        logic        upper;
        logic [11:0] offset;
        logic [11:0] span;
        logic [20:0] scaled;
        logic [9:0]  half;
        upper = (value >= cal_mid);
        if (upper)
        begin
            offset = value - cal_mid;
            span   = (cal_high > cal_mid) ? cal_high - cal_mid : 12'd1;
        end
        else
        begin
            offset = cal_mid - value;
            span   = (cal_mid > cal_low) ? cal_mid - cal_low : 12'd1;
        end
        // floor(500 * offset / span), pinned at 500 past the limit
        scaled = (21'(offset) * 21'(HALF_SCALE)) / 21'(span);
        if (scaled > 21'(HALF_SCALE))
            scaled = 21'(HALF_SCALE);
        half = upper ? HALF_SCALE + scaled[9:0] : HALF_SCALE - scaled[9:0];
        if (cal_reverse)
            half = FULL_SCALE - half;
        return POS_BASE + 11'(half);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // Record accepted sample requests, check each accepted position in order
    always @(posedge clk)
    begin : check_positions
        logic [POS_BITS-1:0] want;
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
            begin
                expected_positions.push_back(predict_position(sample));
                samples_sent++;
            end
            if (position_valid && !position_stall)
            begin
                if (expected_positions.size() == 0)
                    report_mismatch($sformatf("position %0d with no request pending", position));
                else
                begin
                    want = expected_positions.pop_front();
                    positions_checked++;
                    if (position !== want)
                        report_mismatch($sformatf("position %0d, expected %0d", position, want));
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold when requested
    initial
    begin : receiver
        int hold_left;
        hold_left      = 0;
        position_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                position_stall <= 1'b1;
            end
            else
                position_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (position_valid && !position_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Offer one sample request, with a random gap first; returns at a falling edge
    task automatic send_sample(input logic [11:0] value);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample       <= value;
        sample_valid <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!sample_stall)
                break;
        end
        @(negedge clk);
    endtask

    // Wait until every pending position has arrived and the pipeline is empty
    task automatic drain_pipeline();
        sample_valid <= 1'b0;
        while (expected_positions.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [11:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        case (idx)
            REG_LIMIT_HIGH:   cal_high    = value;
            REG_LIMIT_LOW:    cal_low     = value;
            REG_LIMIT_MIDDLE: cal_mid     = value;
            REG_REVERSE_DIR:  cal_reverse = value[0];
            default:          ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_limits(input logic [11:0] hi, input logic [11:0] lo,
                              input logic [11:0] mid, input logic rev);
        drain_pipeline();
        write_reg(REG_LIMIT_HIGH, hi);
        write_reg(REG_LIMIT_LOW, lo);
        write_reg(REG_LIMIT_MIDDLE, mid);
        write_reg(REG_REVERSE_DIR, {11'd0, rev});
    endtask

    // Mostly ordered limits; otherwise anything, including inverted spans
    task automatic randomize_limits(input bit well_formed);
        int lo;
        int mid;
        int hi;
        if (well_formed)
        begin
            lo  = $urandom_range(0, 1500);
            mid = lo + $urandom_range(1, 1200);
            hi  = mid + $urandom_range(1, 4095 - mid);
        end
        else
        begin
            lo  = $urandom_range(0, 4095);
            mid = $urandom_range(0, 4095);
            hi  = $urandom_range(0, 4095);
        end
        set_limits(12'(hi), 12'(lo), 12'(mid), 1'($urandom_range(1)));
    endtask

    // Sample inside the calibrated range, near center, or anywhere
    function automatic logic [11:0] random_sample();
        int pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 60)
            v = $urandom_range(cal_low, cal_high);
        else if (pick < 75)
        begin
            v = int'(cal_mid) + int'($urandom_range(16)) - 8;
            if (v < 0)
                v = 0;
            if (v > 4095)
                v = 4095;
        end
        else
            v = $urandom_range(4095);
        return 12'(v);
    endfunction

    task automatic test_reset_defaults();
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd2048);
        send_sample(12'd2047);
        drain_pipeline();
    endtask

    // Both limits, center, and overshoot past each limit
    task automatic test_directed_limits();
        set_limits(12'd3800, 12'd200, 12'd2000, 1'b0);
        send_sample(12'd200);
        send_sample(12'd3800);
        send_sample(12'd2000);
        send_sample(12'd100);
        send_sample(12'd4000);
        drain_pipeline();
    endtask

    task automatic test_reverse_mirror();
        write_reg(REG_REVERSE_DIR, 12'd1);
        send_sample(12'd200);
        send_sample(12'd3800);
        send_sample(12'd2900);
        drain_pipeline();
    endtask

    // Empty or inverted half-spans on both sides
    task automatic test_degenerate_spans();
        set_limits(12'd1000, 12'd3500, 12'd3000, 1'b0);
        send_sample(12'd3000);
        send_sample(12'd3001);
        send_sample(12'd2999);
        send_sample(12'd0);
        send_sample(12'd4095);
        drain_pipeline();
    endtask

    task automatic test_register_extremes();
        set_limits(12'd0, 12'd0, 12'd0, 1'b0);
        send_sample(12'd0);
        send_sample(12'd4095);
        set_limits(12'd4095, 12'd4095, 12'd4095, 1'b1);
        send_sample(12'd0);
        send_sample(12'd4095);
        drain_pipeline();
    endtask

    // Four idle/stall mixes, each with an ordered and an arbitrary calibration
    task automatic test_random_traffic();
        int send_pct[4] = '{0, 53, 0, 25};
        int recv_pct[4] = '{0, 0, 53, 25};
        for (int mode = 0; mode < 4; mode++)
        begin
            for (int setting = 0; setting < 2; setting++)
            begin
                randomize_limits(setting == 0);
                send_idle_pct  = send_pct[mode];
                recv_stall_pct = recv_pct[mode];
                for (int n = 0; n < ITEMS_PER_SET; n++)
                    send_sample(random_sample());
                drain_pipeline();
            end
        end
    endtask

    // Long output hold while requests keep coming, so the input side stalls
    task automatic test_backpressure();
        randomize_limits(1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 25;
        hold_req       = 1'b1;
        for (int n = 0; n < 40; n++)
            send_sample(random_sample());
        drain_pipeline();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_LIMIT_HIGH;
        cfg_data     = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_directed_limits();
        test_reverse_mirror();
        test_degenerate_spans();
        test_register_extremes();
        test_random_traffic();
        test_backpressure();
        drain_pipeline();

        $display("Checked %0d positions from %0d samples: reset, directed and degenerate limits,",
                 positions_checked, samples_sent);
        $display("reverse mode, random calibrations under four idle/stall mixes, long output hold.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
